// ===== rtl/scti_pkg.sv =====
// Package for the sine/cosine table interpolator: widths, constants and ROM builder.
package scti_pkg;

    localparam int TABLE_ENTRIES       = 512;
    localparam int ANGLE_FRACTION_BITS = 16;

    localparam int ANGLE_W  = 24;
    localparam int VALUE_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int PHASE_W  = 32;
    localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W   = IDX_BITS + 1;
    localparam int CONST_W  = 31;
    localparam int PROD_W   = ANGLE_W + CONST_W;

    typedef enum logic [0:0] {
        CMD_SINE   = 1'b0,
        CMD_COSINE = 1'b1
    } t_command;

    typedef logic signed [VALUE_W-1:0] t_sample;
    typedef t_sample t_rom [0:TABLE_ENTRIES];

    // 1/(2*pi) as a Q0.32 fraction, held in a signed 31-bit constant
    localparam logic signed [CONST_W-1:0] INV_TWO_PI_Q32 = 31'sd683565276;
    localparam logic [PHASE_W-1:0]        QUARTER_TURN   = 32'h4000_0000;
    localparam logic [63:0]               HALF_PI_Q30    = 64'd1686629713;

    // Taylor series of sin on [0, pi/2], argument and result in Q2.30
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 8; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        return unsigned'(sum);
    endfunction

    // Entry k = round(32768*sin(2*pi*k/TABLE_ENTRIES)), saturated to 16 bits
    function automatic t_rom build_rom();
        t_rom               rom;
        logic [63:0]        p;
        logic [63:0]        quad;
        logic [63:0]        rem;
        logic [63:0]        x;
        logic [63:0]        m;
        logic signed [63:0] v;
        for (int k = 0; k <= TABLE_ENTRIES; k++) begin
            p    = 64'(4 * k);
            quad = (p / 64'(TABLE_ENTRIES)) & 64'd3;
            rem  = p % 64'(TABLE_ENTRIES);
            if (quad[0]) begin
                rem = 64'(TABLE_ENTRIES) - rem;
            end
            x = (HALF_PI_Q30 * rem + 64'(TABLE_ENTRIES / 2)) / 64'(TABLE_ENTRIES);
            m = (sin_q30(x) + 64'd16384) >> 15;
            if (m > 64'd32768) begin
                m = 64'd32768;
            end
            v = (quad >= 64'd2) ? -signed'(m) : signed'(m);
            if (v > 64'sd32767) begin
                v = 64'sd32767;
            end
            rom[k] = t_sample'(v[VALUE_W-1:0]);
        end
        return rom;
    endfunction

endpackage

// ===== rtl/sine_cosine_table_interpolator.sv =====
// Pipelined sine/cosine: angle scaling, ROM lookup and linear interpolation.
//
//  channel | signals                              | role
//  --------+--------------------------------------+-------------------------------
//  in      | i_valid o_ready i_command i_angle    | select + Q8.16 radian angle
//  out     | o_valid i_ready o_value              | Q1.15 sine or cosine
//
// Four register stages: multiply to phase, dual-port ROM read, slope multiply,
// round/clamp into the output register. One transfer per cycle while the output is not stalled.
// Throughput is set by the per-stage enables; each stage only holds when the
// next one is full and stalled, so bubbles get squeezed out.
// Synchronous active-low reset clears the valid bits only.
module sine_cosine_table_interpolator
    import scti_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [0:0]                i_command,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [VALUE_W-1:0] o_value
);

    localparam t_rom SIN_ROM = build_rom();

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_adv1, w_adv2, w_adv3, w_adv4;

    // stage 1
    logic [PHASE_W-1:0]       r_phase;
    t_command                 r_cmd;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [63:0]       w_prod_ext;

    // stage 2
    logic [PHASE_W-1:0]  w_phase2;
    logic [ADDR_W-1:0]   w_addr_a;
    logic [ADDR_W-1:0]   w_addr_b;
    t_sample             r_a2;
    t_sample             r_b2;
    logic [FRAC_W-1:0]   r_frac2;

    // stage 3
    logic signed [VALUE_W:0]        w_diff;
    logic signed [2*VALUE_W+1:0]    r_mul3;
    t_sample                        r_a3;

    // stage 4
    logic signed [2*VALUE_W+2:0]    w_sum;
    logic signed [VALUE_W+2:0]      w_val;
    logic signed [VALUE_W-1:0]      w_sat;
    logic signed [VALUE_W-1:0]      r_value;

    assign w_adv4  = !r_v4 || i_ready;
    assign w_adv3  = !r_v3 || w_adv4;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r_v4;
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
        end
    end

    // stage 1: angle times 1/(2*pi), keep 32 fraction-of-turn bits (floor)
    assign w_prod     = i_angle * INV_TWO_PI_Q32;
    assign w_prod_ext = 64'(w_prod);

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_phase <= w_prod_ext[ANGLE_FRACTION_BITS+PHASE_W-1 -: PHASE_W];
            r_cmd   <= t_command'(i_command);
        end
    end

    // stage 2: quarter turn for cosine, wraps mod one; top bits address the ROM
    always_comb begin
        w_phase2 = r_phase;
        if (r_cmd == CMD_COSINE) begin
            w_phase2 = r_phase + QUARTER_TURN;
        end
        w_addr_a = {1'b0, w_phase2[PHASE_W-1 -: IDX_BITS]};
        w_addr_b = w_addr_a + ADDR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_a2    <= SIN_ROM[w_addr_a];
            r_b2    <= SIN_ROM[w_addr_b];
            r_frac2 <= w_phase2[PHASE_W-IDX_BITS-1 -: FRAC_W];
        end
    end

    // stage 3: slope times fraction
    assign w_diff = (VALUE_W+1)'(r_b2) - (VALUE_W+1)'(r_a2);

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_mul3 <= w_diff * $signed({1'b0, r_frac2});
            r_a3   <= r_a2;
        end
    end

    // stage 4: round to nearest (floor of +half), clamp to Q1.15
    always_comb begin
        w_sum = ((2*VALUE_W+3)'(r_a3) <<< FRAC_W) + (2*VALUE_W+3)'(r_mul3)
              + (2*VALUE_W+3)'(1 << (FRAC_W - 1));
        w_val = w_sum[FRAC_W +: VALUE_W+3];
        priority if (w_val > (VALUE_W+3)'(32767)) begin
            w_sat = 16'sh7FFF;
        end else if (w_val < -(VALUE_W+3)'(32768)) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = w_val[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_value <= w_sat;
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench for sine_cosine_table_interpolator: directed table, random angles, bit-exact checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scti_pkg::*;

    localparam longint INV_TWO_PI = 64'sd683565276;
    localparam longint HALF_PI    = 64'sd1686629713;
    localparam int     QUARTER    = 102944;   // pi/2 in Q8.16
    localparam int     HOLD_LEN   = 80;

    typedef struct packed {
        t_command                  cmd;
        logic signed [ANGLE_W-1:0] angle;
        logic                      known;
        t_sample                   value;
    } t_stim_row;

    logic                      i_clk     = 1'b0;
    logic                      i_rst_n   = 1'b0;
    logic                      i_valid   = 1'b0;
    logic [0:0]                i_command = 1'b0;
    logic signed [ANGLE_W-1:0] i_angle   = '0;
    logic                      i_ready   = 1'b0;
    logic                      o_ready;
    logic                      o_valid;
    logic signed [VALUE_W-1:0] o_value;

    longint    sine_lut [0:TABLE_ENTRIES];
    t_sample   expected_values [$];
    t_stim_row offered_items [$];
    int        fail_count  = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        hold_asks   = 0;

    // known values only where they are obvious; the rest go through the predictor
    t_stim_row directed_rows [0:18] = '{
        '{CMD_SINE,   24'sd0,          1'b1, 16'sd0},
        '{CMD_COSINE, 24'sd0,          1'b1, 16'sd32767},
        '{CMD_SINE,   24'sd8388607,    1'b0, 16'sd0},
        '{CMD_SINE,   -24'sd8388608,   1'b0, 16'sd0},
        '{CMD_COSINE, 24'sd8388607,    1'b0, 16'sd0},
        '{CMD_COSINE, -24'sd8388608,   1'b0, 16'sd0},
        '{CMD_SINE,   24'sd1,          1'b0, 16'sd0},
        '{CMD_SINE,   -24'sd1,         1'b0, 16'sd0},
        '{CMD_COSINE, -24'sd1,         1'b0, 16'sd0},
        '{CMD_SINE,   24'sd102944,     1'b0, 16'sd0},
        '{CMD_SINE,   24'sd205887,     1'b0, 16'sd0},
        '{CMD_SINE,   -24'sd102944,    1'b0, 16'sd0},
        '{CMD_SINE,   24'sd411775,     1'b0, 16'sd0},
        '{CMD_COSINE, 24'sd205887,     1'b0, 16'sd0},
        '{CMD_COSINE, 24'sd102944,     1'b0, 16'sd0},
        '{CMD_SINE,   24'sh555555,     1'b0, 16'sd0},
        '{CMD_SINE,   24'shAAAAAA,     1'b0, 16'sd0},
        '{CMD_COSINE, 24'sh555555,     1'b0, 16'sd0},
        '{CMD_COSINE, 24'shAAAAAA,     1'b0, 16'sd0}
    };

    sine_cosine_table_interpolator i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .i_angle   (i_angle),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_value   (o_value)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("sine_cosine_table_interpolator: mismatch");
        $finish;
    end

    // sin(x), x in [0, pi/2], Q2.30 in and out, truncated Taylor series
    function automatic longint taylor_sine_q30(input longint x);
        logic [63:0] sq;
        logic [63:0] term;
        longint      sum;
        sq   = (64'(x) * 64'(x)) >> 30;
        term = 64'(x);
        sum  = x;
        for (int n = 1; n <= 8; n++) begin
            term = (term * sq) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        return (sum < 0) ? 64'sd0 : sum;
    endfunction

    function automatic void fill_sine_lut();
        longint p;
        longint quad;
        longint rem;
        longint x;
        longint mag;
        longint v;
        for (int k = 0; k <= TABLE_ENTRIES; k++) begin
            p    = 4 * k;
            quad = (p / TABLE_ENTRIES) % 4;
            rem  = p % TABLE_ENTRIES;
            if (quad % 2 == 1) begin
                rem = TABLE_ENTRIES - rem;
            end
            x   = (HALF_PI * rem + TABLE_ENTRIES / 2) / TABLE_ENTRIES;
            mag = (taylor_sine_q30(x) + 16384) >>> 15;
            if (mag > 32768) begin
                mag = 32768;
            end
            v = (quad >= 2) ? -mag : mag;
            sine_lut[k] = (v > 32767) ? 64'sd32767 : v;
        end
    endfunction

    function automatic t_sample predict_trig_value(input t_command cmd,
                                                   input logic signed [ANGLE_W-1:0] ang);
        logic signed [63:0] prod;
        logic [31:0]        phase;
        logic [63:0]        scaled;
        longint             idx;
        longint             frac;
        longint             a;
        longint             b;
        longint             acc;
        prod  = longint'(ang) * INV_TWO_PI;
        phase = prod[ANGLE_FRACTION_BITS +: 32];
        if (cmd == CMD_COSINE) begin
            phase = phase + QUARTER_TURN;
        end
        scaled = 64'(phase) * 64'(TABLE_ENTRIES);
        idx    = longint'(scaled[63:32]);
        if (idx >= TABLE_ENTRIES) begin
            idx = TABLE_ENTRIES - 1;
        end
        frac = longint'(scaled[31:16]);
        a    = sine_lut[idx];
        b    = sine_lut[idx + 1];
        acc  = (a * 65536 + (b - a) * frac + 32768) >>> 16;
        if (acc > 32767) begin
            acc = 32767;
        end
        if (acc < -32768) begin
            acc = -32768;
        end
        return t_sample'(acc[VALUE_W-1:0]);
    endfunction

    // accepted transfers on both channels; outputs first, latency keeps them apart
    always @(posedge i_clk) begin
        t_stim_row row;
        t_sample   exp_val;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_values.size() == 0) begin
                    $error("value: expected none, actual %0d", o_value);
                    fail_count++;
                end else begin
                    exp_val = expected_values.pop_front();
                    if (o_value !== exp_val) begin
                        $error("value: expected %0d, actual %0d", exp_val, o_value);
                        fail_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                row = offered_items.pop_front();
                if (row.known) begin
                    expected_values.push_back(row.value);
                end else begin
                    expected_values.push_back(predict_trig_value(t_command'(i_command),
                                                                 i_angle));
                end
            end
        end
    end

    // output side: random back-pressure plus long hold-offs on request
    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                hold_left   = HOLD_LEN;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_item(input t_stim_row row);
        bit hit;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= row.cmd;
        i_angle   <= row.angle;
        offered_items.push_back(row);
        // inputs only move at rising edges, so o_ready at the falling edge decides the transfer
        do begin
            @(negedge i_clk);
            hit = o_ready;
            @(posedge i_clk);
        end while (!hit);
    endtask

    task automatic send_random();
        t_stim_row row;
        int        sel;
        int        k;
        sel       = $urandom_range(3);
        row.cmd   = t_command'($urandom_range(1));
        row.known = 1'b0;
        row.value = '0;
        if (sel < 2) begin
            row.angle = ANGLE_W'($urandom());
        end else if (sel == 2) begin
            row.angle = ANGLE_W'(int'($urandom_range(823550)) - 411775);
        end else begin
            // near multiples of a quarter turn, where the table folds
            k         = int'($urandom_range(160)) - 80;
            row.angle = ANGLE_W'(k * QUARTER + int'($urandom_range(16)) - 8);
        end
        send_item(row);
    endtask

    initial begin
        fill_sine_lut();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 18;
        rx_idle_pct = 83;
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i]);
        end
        for (int i = 0; i < 140; i++) begin
            send_random();
        end

        tx_idle_pct = 83;
        rx_idle_pct = 18;
        for (int i = 0; i < 140; i++) begin
            send_random();
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < 120; i++) begin
            if (i == 20) begin
                hold_asks++;
            end
            send_random();
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (expected_values.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("sine_cosine_table_interpolator: match");
        end else begin
            $display("sine_cosine_table_interpolator: mismatch");
        end
        $finish;
    end

endmodule
